// File: src/dfr_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result status codes,
// header constants and the entry type that moves between the front and the back.
// Depends on nothing; the front, queue, back and top files refer to it by scoped names.
package dfr_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int LEN_W = 64;
  localparam int KEY_W = 32;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_HDR_TRUNC = 2'd2,
    ST_PAY_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [7:0]       key_byte;
    logic             fin;
    logic [3:0]       opcode;
    logic             masked;
    logic [LEN_W-1:0] length;
    logic             last;
    status_t          status;
  } q_entry_t;

endpackage

// File: src/dfr_in_if.sv
// Input channel of the deframer: one received frame byte per transfer.
// Stands alone; uses no package.
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_start;
  logic       chunk_end;

  modport source(output valid, rx_byte, chunk_start, chunk_end, input ready);
  modport sink(input valid, rx_byte, chunk_start, chunk_end, output ready);
endinterface

// File: src/dfr_out_if.sv
// Output channel of the deframer: one unmasked payload byte or status result
// per transfer. Stands alone; uses no package.
interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        final_fragment;
  logic [3:0]  frame_opcode;
  logic        was_masked;
  logic [63:0] frame_length;
  logic        last_of_frame;
  logic [1:0]  status;

  modport source(output valid, payload_byte, final_fragment, frame_opcode, was_masked,
                 frame_length, last_of_frame, status, input ready);
  modport sink(input valid, payload_byte, final_fragment, frame_opcode, was_masked,
               frame_length, last_of_frame, status, output ready);
endinterface

// File: src/dfr_front.sv
// Front end of the deframer: accepts frame bytes, walks the header and
// classifies each byte, pushing one queue entry for every result it causes.
// Depends on dfr_pkg and dfr_in_if.
module dfr_front (
  input  logic              clk,
  input  logic              rst,
  dfr_in_if.sink            rx,
  input  logic              q_full,
  output logic              q_push,
  output dfr_pkg::q_entry_t q_data
);

  dfr_pkg::phase_t              phase, phase_next, phase_eff, phase_adv;
  logic [3:0]                   ext_left, ext_left_next;
  logic [2:0]                   key_left, key_left_next;
  logic                         fin, fin_next;
  logic [3:0]                   opcode, opcode_next;
  logic                         mask_flag, mask_flag_next;
  logic [dfr_pkg::LEN_W-1:0]    length, length_next;
  logic [dfr_pkg::KEY_W-1:0]    mask_key, mask_key_next;
  logic [dfr_pkg::LEN_W-1:0]    pidx, pidx_next;

  logic       accept;
  logic       len_done;
  logic       hdr_done;
  logic       empty_frame;
  logic       data_last;
  logic [1:0] key_sel;
  logic [7:0] key_byte;
  logic       emit;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  assign phase_eff = rx.chunk_start ? dfr_pkg::PH_HDR0 : phase;

  // Key byte for this payload position; the first key byte received is index 0.
  assign key_sel  = 2'd3 - pidx[1:0];
  assign key_byte = mask_key[{key_sel, 3'b000} +: 8];

  // Register updates and the phase before the chunk-end rule is applied.
  always_comb begin
    ext_left_next  = ext_left;
    key_left_next  = key_left;
    fin_next       = fin;
    opcode_next    = opcode;
    mask_flag_next = mask_flag;
    length_next    = length;
    mask_key_next  = mask_key;
    pidx_next      = pidx;
    phase_adv      = phase_eff;
    len_done       = 1'b0;
    hdr_done       = 1'b0;
    data_last      = 1'b0;
    unique case (phase_eff)
      dfr_pkg::PH_HDR1: begin
        mask_flag_next = rx.rx_byte[7];
        if (rx.rx_byte[6:0] == dfr_pkg::LEN_CODE_16) begin
          ext_left_next = dfr_pkg::EXT_BYTES_16;
          phase_adv     = dfr_pkg::PH_EXT;
        end else if (rx.rx_byte[6:0] == dfr_pkg::LEN_CODE_64) begin
          ext_left_next = dfr_pkg::EXT_BYTES_64;
          phase_adv     = dfr_pkg::PH_EXT;
        end else begin
          length_next = {{(dfr_pkg::LEN_W-7){1'b0}}, rx.rx_byte[6:0]};
          len_done    = 1'b1;
        end
      end
      dfr_pkg::PH_EXT: begin
        length_next   = {length[dfr_pkg::LEN_W-9:0], rx.rx_byte};
        ext_left_next = ext_left - 4'd1;
        len_done      = (ext_left_next == 4'd0);
      end
      dfr_pkg::PH_KEY: begin
        mask_key_next = {mask_key[dfr_pkg::KEY_W-9:0], rx.rx_byte};
        key_left_next = key_left - 3'd1;
        hdr_done      = (key_left_next == 3'd0);
      end
      dfr_pkg::PH_DATA: begin
        pidx_next = pidx + 64'd1;
        data_last = (pidx_next == length);
        phase_adv = data_last ? dfr_pkg::PH_HDR0 : dfr_pkg::PH_DATA;
      end
      default: begin
        // First header byte, also taken for any phase code that means nothing.
        fin_next       = rx.rx_byte[7];
        opcode_next    = rx.rx_byte[3:0];
        mask_flag_next = 1'b0;
        length_next    = '0;
        mask_key_next  = '0;
        pidx_next      = '0;
        ext_left_next  = '0;
        key_left_next  = '0;
        phase_adv      = dfr_pkg::PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_flag_next) begin
        key_left_next = dfr_pkg::KEY_BYTES;
        phase_adv     = dfr_pkg::PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    empty_frame = 1'b0;
    if (hdr_done) begin
      pidx_next = '0;
      if (length_next == '0) begin
        empty_frame = 1'b1;
        phase_adv   = dfr_pkg::PH_HDR0;
      end else begin
        phase_adv = dfr_pkg::PH_DATA;
      end
    end

    // A chunk end always sends the parse back to the first header byte.
    phase_next = rx.chunk_end ? dfr_pkg::PH_HDR0 : phase_adv;
  end

  // Result classification.
  always_comb begin
    emit             = 1'b0;
    q_data.data_byte = '0;
    q_data.key_byte  = '0;
    q_data.fin       = fin_next;
    q_data.opcode    = opcode_next;
    q_data.masked    = mask_flag_next;
    q_data.length    = length_next;
    q_data.last      = 1'b0;
    q_data.status    = dfr_pkg::ST_PAYLOAD;
    if (phase_eff == dfr_pkg::PH_DATA) begin
      emit = 1'b1;
      if (data_last || !rx.chunk_end) begin
        q_data.data_byte = rx.rx_byte;
        q_data.key_byte  = key_byte;
        q_data.last      = data_last;
      end else begin
        q_data.status = dfr_pkg::ST_PAY_TRUNC;
      end
    end else if (empty_frame) begin
      emit          = 1'b1;
      q_data.last   = 1'b1;
      q_data.status = dfr_pkg::ST_EMPTY;
    end else if (rx.chunk_end && phase_adv != dfr_pkg::PH_HDR0) begin
      emit          = 1'b1;
      q_data.status = (phase_adv == dfr_pkg::PH_DATA) ? dfr_pkg::ST_PAY_TRUNC
                                                      : dfr_pkg::ST_HDR_TRUNC;
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dfr_pkg::PH_HDR0;
      ext_left  <= '0;
      key_left  <= '0;
      fin       <= 1'b0;
      opcode    <= '0;
      mask_flag <= 1'b0;
      length    <= '0;
      mask_key  <= '0;
      pidx      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      ext_left  <= ext_left_next;
      key_left  <= key_left_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      mask_flag <= mask_flag_next;
      length    <= length_next;
      mask_key  <= mask_key_next;
      pidx      <= pidx_next;
    end
  end

endmodule

// File: src/dfr_queue.sv
// Short first-in first-out queue of classified results between the deframer
// front and back. Depends on dfr_pkg for the entry type.
module dfr_queue #(
  parameter int Depth = dfr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dfr_pkg::q_entry_t push_data,
  input  logic              pop,
  output dfr_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dfr_pkg::q_entry_t slots [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full     = (count == FullCnt);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: src/dfr_back.sv
// Back end of the deframer: takes queued results, unmasks payload bytes and
// holds each result in the output register until it is taken.
// Depends on dfr_pkg and dfr_out_if.
module dfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  dfr_pkg::q_entry_t q_data,
  output logic              q_pop,
  dfr_out_if.source         tx
);

  logic load;

  assign load  = !q_empty && (!tx.valid || tx.ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (load) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx.payload_byte   <= (q_data.status == dfr_pkg::ST_PAYLOAD)
                           ? (q_data.data_byte ^ q_data.key_byte) : 8'd0;
      tx.final_fragment <= q_data.fin;
      tx.frame_opcode   <= q_data.opcode;
      tx.was_masked     <= q_data.masked;
      tx.frame_length   <= q_data.length;
      tx.last_of_frame  <= q_data.last;
      tx.status         <= q_data.status;
    end
  end

endmodule

// File: src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: front parser, result queue and
// unmasking output stage. Depends on dfr_pkg, dfr_in_if, dfr_out_if,
// dfr_front, dfr_queue and dfr_back.
//
//   Channel  Direction  Carries
//   rx       in         rx_byte, chunk_start, chunk_end (one frame byte)
//   tx       out        payload_byte, final_fragment, frame_opcode, was_masked,
//                       frame_length, last_of_frame, status (at most one per byte)
//
// One byte is accepted every cycle while the result queue is not full; the header
// parse and the classification of a byte are done in the cycle of its transfer,
// set by the 64-bit length compare. A result is written into the result queue when
// its byte is taken and moves on to the output register once the entries ahead
// of it have gone and the output register is free. Reset is synchronous;
// afterwards the parse waits for a first header byte with all header fields zero.
// rx.ready falls only when the result queue holds QueueDepth entries, which
// happens only when tx is stalled; either side may stall without losing data.
module websocket_frame_deframer #(
  parameter int QueueDepth = dfr_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  dfr_in_if.sink    rx,
  dfr_out_if.source tx
);

  // Entries carry the raw byte and its key byte along with the header fields
  // as they stand after that byte, so the back end needs no frame state.
  dfr_pkg::q_entry_t push_data;
  dfr_pkg::q_entry_t pop_data;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  dfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  dfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // The back end reloads its output register whenever the queue holds an entry and the
  // register is empty or being taken, so a stream drains at one per cycle while tx.ready stays high.
  dfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .tx      (tx)
  );

endmodule
